// File: rtl/core/deq_pkg.sv
// Package for the double-ended queue core: depth, index widths, operation
// codes, request, response and pointer update structs and ring index helpers.
// No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	typedef enum logic [1:0] {
		OP_PUSH_LEFT  = 2'd0,
		OP_PUSH_RIGHT = 2'd1,
		OP_POP_LEFT   = 2'd2,
		OP_POP_RIGHT  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                      operation;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] left_value;
		logic signed [WORD_W-1:0] right_value;
		logic [CNT_W-1:0]         occupancy;
		logic                     is_empty;
		logic                     is_full;
		logic                     rejected;
	} rsp_t;

	// pointer update handed from the pointer unit to the slot memory
	typedef struct packed {
		logic             push_ok;
		logic [IDX_W-1:0] waddr;
		logic [IDX_W-1:0] new_left;
		logic [IDX_W-1:0] new_right;
		logic [CNT_W-1:0] new_count;
		logic             rejected;
	} ptr_upd_t;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

endpackage

// File: rtl/core/deq_ptr.sv
// Pointer unit of the double-ended queue: left and right slot indices and
// the element count, with the next-state update for one request.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_ptr (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  deq_pkg::op_t    operation,
	output deq_pkg::ptr_upd_t upd
);
	import deq_pkg::*;

	logic [IDX_W-1:0] left_q;
	logic [IDX_W-1:0] right_q;
	logic [CNT_W-1:0] count_q;
	logic             empty;
	logic             full;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));

	// right always equals left + count - 1 around the ring, also when empty
	always_comb begin
		upd.push_ok   = 1'b0;
		upd.waddr     = idx_dec(left_q);
		upd.new_left  = left_q;
		upd.new_right = right_q;
		upd.new_count = count_q;
		upd.rejected  = 1'b0;
		unique case (operation)
			OP_PUSH_LEFT: begin
				if (full) begin
					upd.rejected = 1'b1;
				end else begin
					upd.push_ok   = 1'b1;
					upd.waddr     = idx_dec(left_q);
					upd.new_left  = idx_dec(left_q);
					upd.new_count = count_q + 1'b1;
				end
			end
			OP_PUSH_RIGHT: begin
				if (full) begin
					upd.rejected = 1'b1;
				end else begin
					upd.push_ok   = 1'b1;
					upd.waddr     = idx_inc(right_q);
					upd.new_right = idx_inc(right_q);
					upd.new_count = count_q + 1'b1;
				end
			end
			OP_POP_LEFT: begin
				if (empty) begin
					upd.rejected = 1'b1;
				end else begin
					upd.new_left  = idx_inc(left_q);
					upd.new_count = count_q - 1'b1;
				end
			end
			OP_POP_RIGHT: begin
				if (empty) begin
					upd.rejected = 1'b1;
				end else begin
					upd.new_right = idx_dec(right_q);
					upd.new_count = count_q - 1'b1;
				end
			end
			default: begin
				upd.rejected = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			right_q <= IDX_W'(DEPTH - 1);
			count_q <= '0;
		end else if (accept) begin
			left_q  <= upd.new_left;
			right_q <= upd.new_right;
			count_q <= upd.new_count;
		end
	end

endmodule

// File: rtl/core/double_ended_queue_core.sv
// Top level of the double-ended queue core: slot memory, response stage.
// Depends on deq_pkg and deq_ptr.
//
// Usage:
//   A request (req.operation, req.value) is taken at a rising edge where
//   start is high and busy is low. Operations: push left, push right,
//   pop left, pop right. One response per request appears on rsp with done
//   high for exactly one cycle, in the cycle after the request edge.
//   Throughput: one request per cycle while busy is low. Each request writes
//   at most one slot and reads both end slots from the memory in the same
//   edge; the pushed word is forwarded where it lands on an end being read.
//   Pops on empty and pushes on full leave the state alone and set
//   rsp.rejected. End values read as zero when the queue is empty.
//   Reset: asynchronous, active low; the queue is empty afterwards and busy
//   is high for the first cycle after release. The slot memory is not
//   cleared: only slots holding elements are ever shown.
//   The receiver cannot stall; a response must be taken in its cycle.
`timescale 1ns / 1ps

module double_ended_queue_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  deq_pkg::req_t req,
	output logic          done,
	output deq_pkg::rsp_t rsp
);
	import deq_pkg::*;

	logic              accept;
	ptr_upd_t          upd;
	logic              busy_q;
	logic              done_s1;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_l_s1;
	logic [WORD_W-1:0] rd_r_s1;
	logic [WORD_W-1:0] value_s1;
	logic              fwd_l_s1;
	logic              fwd_r_s1;
	logic [CNT_W-1:0]  count_s1;
	logic              rej_s1;
	logic              empty_s1;

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	deq_ptr u_ptr (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (req.operation),
		.upd       (upd)
	);

	// read-before-write memory; same-slot hits are forwarded below
	always_ff @(posedge clk) begin
		if (accept && upd.push_ok) begin
			mem[upd.waddr] <= req.value;
		end
		if (accept) begin
			rd_l_s1  <= mem[upd.new_left];
			rd_r_s1  <= mem[upd.new_right];
			value_s1 <= req.value;
			fwd_l_s1 <= upd.push_ok && (upd.waddr == upd.new_left);
			fwd_r_s1 <= upd.push_ok && (upd.waddr == upd.new_right);
			count_s1 <= upd.new_count;
			rej_s1   <= upd.rejected;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			done_s1 <= 1'b0;
		end else begin
			busy_q  <= 1'b0;
			done_s1 <= accept;
		end
	end

	assign empty_s1 = (count_s1 == '0);
	assign done     = done_s1;

	always_comb begin
		rsp.left_value  = empty_s1 ? '0 : (fwd_l_s1 ? value_s1 : rd_l_s1);
		rsp.right_value = empty_s1 ? '0 : (fwd_r_s1 ? value_s1 : rd_r_s1);
		rsp.occupancy   = count_s1;
		rsp.is_empty    = empty_s1;
		rsp.is_full     = (count_s1 == CNT_W'(DEPTH));
		rsp.rejected    = rej_s1;
	end

endmodule

// File: rtl/core/deq_chk.sv
// Port-level checks for the double-ended queue core, bound to the top level.
// Depends on deq_pkg and double_ended_queue_core.
`timescale 1ns / 1ps

module deq_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input deq_pkg::req_t req,
	input logic          done,
	input deq_pkg::rsp_t rsp
);
	import deq_pkg::*;

	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("request not answered in the next cycle");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("response without request");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.is_empty == (rsp.occupancy == '0)))
		else $error("empty flag disagrees with occupancy");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.is_empty) |-> (rsp.left_value == '0 && rsp.right_value == '0))
		else $error("end values not zero on empty queue");

	a_push_left_end: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.operation == OP_PUSH_LEFT) |=>
		(rsp.rejected || rsp.left_value == $past(req.value)))
		else $error("pushed word not at left end");

endmodule

bind double_ended_queue_core deq_chk u_deq_chk (.*);
